@@ design/pist_pkg.sv @@
package pist_pkg;

	localparam int OP_W    = 2;
	localparam int COORD_W = 32;
	localparam int SIZE_W  = 31;
	localparam int ROT_W   = 16;

	// angle resolution: low ANGLE_BITS of rotation are a fraction of one turn
	localparam int ANGLE_BITS = 16;
	localparam int PHASE_W    = 32;

	localparam int CORDIC_STEPS = 24;
	localparam int CS_W         = 32;
	localparam int CS_FRAC      = 30;
	localparam int Z_W          = 33;

	localparam logic signed [CS_W-1:0] CORDIC_GAIN  = 32'sd652032874;
	localparam logic signed [Z_W-1:0]  QUARTER_TURN = 33'sd1073741824;
	localparam logic signed [Z_W-1:0]  HALF_TURN    = 33'sd2147483648;
	localparam logic [SIZE_W-1:0]      SQRT3_Q30    = 31'd1859775393;

	localparam logic signed [Z_W-1:0] ATAN_TURNS [CORDIC_STEPS] = '{
		33'h20000000, 33'h12E4051E, 33'h09FB385B, 33'h051111D4,
		33'h028B0D43, 33'h0145D7E1, 33'h00A2F61E, 33'h00517C55,
		33'h0028BE53, 33'h00145F2F, 33'h000A2F98, 33'h000517CC,
		33'h00028BE6, 33'h000145F3, 33'h0000A2FA, 33'h0000517D,
		33'h000028BE, 33'h0000145F, 33'h00000A30, 33'h00000518,
		33'h0000028C, 33'h00000146, 33'h000000A3, 33'h00000051
	};

	typedef enum logic [OP_W-1:0] {
		SHAPE_RECT   = 2'd0,
		SHAPE_TRI    = 2'd1,
		SHAPE_CIRCLE = 2'd2
	} shape_t;

endpackage

@@ design/pist_query_if.sv @@
interface pist_query_if;
	import pist_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [OP_W-1:0]           op;
	logic signed [COORD_W-1:0] point_x;
	logic signed [COORD_W-1:0] point_y;
	logic signed [COORD_W-1:0] center_x;
	logic signed [COORD_W-1:0] center_y;
	logic [SIZE_W-1:0]         size_a;
	logic [SIZE_W-1:0]         size_b;
	logic [ROT_W-1:0]          rotation;

	modport source (
		output valid, op, point_x, point_y, center_x, center_y, size_a, size_b, rotation,
		input  ready
	);

	modport sink (
		input  valid, op, point_x, point_y, center_x, center_y, size_a, size_b, rotation,
		output ready
	);

endinterface

@@ design/pist_result_if.sv @@
interface pist_result_if;
	import pist_pkg::*;

	logic valid;
	logic ready;
	logic inside_res;

	modport source (
		output valid, inside_res,
		input  ready
	);

	modport sink (
		input  valid, inside_res,
		output ready
	);

endinterface

@@ design/point_in_shape_hit_test.sv @@
// channel   modport  direction  payload
// query     sink     in         op, point_x, point_y, center_x, center_y, size_a, size_b, rotation
// result    source   out        inside_res
//
// One transaction per cycle sustained while the skid register stays empty; after
// acceptance a query passes stages 2 to 35 and the output register, a depth set by
// the 24-step CORDIC and the 36x36 edge cross products split into 18x18 partial products.
// arst_n clears the stage valid bits and the output/skid flags only.
// The whole pipeline holds while the skid register is full; query.ready is the
// skid-empty flag, so result.ready has no combinational path to query.ready.
module point_in_shape_hit_test (
	input  logic         clk,
	input  logic         arst_n,
	pist_query_if.sink   query,
	pist_result_if.source result
);
	import pist_pkg::*;

	localparam int QW     = COORD_W + 2;
	localparam int DW     = COORD_W + 1;
	localparam int RW     = QW + 1;
	localparam int SQ_W   = 2 * SIZE_W;
	localparam int T_W    = SQ_W - CS_FRAC;
	localparam int PRW    = 65;
	localparam int VW     = 35;
	localparam int OPD_W  = 36;
	localparam int HALF_W = OPD_W / 2;
	localparam int HP_W   = 2 * HALF_W + 1;
	localparam int MID_W  = OPD_W + 2;
	localparam int PW     = 2 * OPD_W;
	localparam int NPROD  = 6;

	localparam int ST_CE   = 1 + CORDIC_STEPS;
	localparam int ST_TRIG = ST_CE + 1;
	localparam int ST_MUL  = ST_TRIG + 1;
	localparam int ST_RND  = ST_MUL + 1;
	localparam int ST_VTX  = ST_RND + 1;
	localparam int ST_OPD  = ST_VTX + 1;
	localparam int ST_PART = ST_OPD + 1;
	localparam int ST_MID  = ST_PART + 1;
	localparam int ST_PROD = ST_MID + 1;
	localparam int ST_CMP  = ST_PROD + 1;
	localparam int NST     = ST_CMP + 1;

	localparam logic [SQ_W-1:0]        T_HALF   = SQ_W'(64'd1 << (CS_FRAC - 1));
	localparam logic signed [PRW-1:0]  RND_HALF = PRW'(64'sd1 <<< (CS_FRAC - 1));
	localparam logic signed [CS_W-1:0] TRIG_LIM = 32'sd1073745920;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic              rect_hit;
		logic              circ_hit;
		logic              size_zero;
		logic              ctr_eq;
		logic [QW-1:0]     qx;
		logic [QW-1:0]     qy;
		logic [SIZE_W-1:0] s;
		logic [T_W-1:0]    t;
	} side_t;

	function automatic logic signed [VW-1:0] rnd30(input logic signed [PRW-1:0] p);
		logic signed [PRW-1:0] r;
		r = p + RND_HALF;
		return VW'(r >>> CS_FRAC);
	endfunction

	logic             go;
	logic [NST:1]     vld_s;
	logic             out_v_q, out_q, skid_v_q, skid_q;
	logic             take;

	// stage 1..3: shape prep
	logic [OP_W-1:0]         op_s1, op_s2, op_s3;
	logic signed [QW-1:0]    qx_s1, qy_s1, qx_s2, qy_s2, qx_s3, qy_s3;
	logic [SIZE_W-1:0]       sa_s1, sb_s1, sa_s2, sa_s3;
	logic                    rect_s2, box_s2, szero_s2, eq_s2;
	logic                    rect_s3, box_s3, szero_s3, eq_s3;
	logic [SIZE_W-1:0]       adx_s2, ady_s2;
	logic [SQ_W-1:0]         tprod_s2;
	logic [SQ_W-1:0]         sqx_s3, sqy_s3, sqr_s3;
	logic [T_W-1:0]          t_s3;

	side_t side_s [4:NST-1];

	logic signed [CS_W-1:0] cx_s [1:ST_CE];
	logic signed [CS_W-1:0] cy_s [1:ST_CE];
	logic signed [Z_W-1:0]  cz_s [1:ST_CE];
	logic                   cf_s [1:ST_CE];

	logic signed [CS_W-1:0] c_s26, sn_s26;
	logic signed [PRW-1:0]  ptc_s27, pts_s27, psc_s27, pss_s27;
	logic signed [VW-1:0]   rss2_s28, rsc2_s28, rtc_s28, rnss_s28;
	logic signed [VW-1:0]   rts_s28, rnsc_s28, rntc_s28, rnts_s28;
	logic signed [VW-1:0]   vx_s29 [3];
	logic signed [VW-1:0]   vy_s29 [3];
	logic signed [OPD_W-1:0] ma_s30 [NPROD];
	logic signed [OPD_W-1:0] mb_s30 [NPROD];
	logic signed [OPD_W-1:0] hh_s31 [NPROD];
	logic signed [HP_W-1:0]  hl_s31 [NPROD];
	logic signed [HP_W-1:0]  lh_s31 [NPROD];
	logic [OPD_W-1:0]        ll_s31 [NPROD];
	logic signed [OPD_W-1:0] hh_s32 [NPROD];
	logic signed [MID_W-1:0] mid_s32 [NPROD];
	logic [OPD_W-1:0]        ll_s32 [NPROD];
	logic signed [PW-1:0]    prod_s33 [NPROD];
	logic [2:0]              lt_s34, gt_s34;
	logic                    hit_s35;

	// stage 1 inputs
	logic signed [DW-1:0]          dx_in, dy_in;
	logic [ROT_W+ANGLE_BITS-1:0]   rot_wide;
	logic [PHASE_W-1:0]            phase;
	logic signed [Z_W-1:0]         z_raw, z_fold;
	logic                          flip_in;

	always_comb begin
		dx_in    = DW'(query.point_x) - DW'(query.center_x);
		dy_in    = DW'(query.point_y) - DW'(query.center_y);
		rot_wide = {ANGLE_BITS'(0), query.rotation};
		phase    = {rot_wide[ANGLE_BITS-1:0], (PHASE_W-ANGLE_BITS)'(0)};
		z_raw    = Z_W'($signed(phase));
		z_fold   = z_raw;
		flip_in  = 1'b0;
		if (z_raw > QUARTER_TURN) begin
			z_fold  = z_raw - HALF_TURN;
			flip_in = 1'b1;
		end else if (z_raw < -QUARTER_TURN) begin
			z_fold  = z_raw + HALF_TURN;
			flip_in = 1'b1;
		end
	end

	// stage 2 box tests
	logic signed [RW-1:0] sa_w, sb_w, qx_w, qy_w;
	logic signed [QW-1:0] hx, hy;
	logic [QW-1:0]        ax, ay;
	logic                 rect_c, box_c;

	always_comb begin
		sa_w   = $signed(RW'(sa_s1));
		sb_w   = $signed(RW'(sb_s1));
		qx_w   = RW'(qx_s1);
		qy_w   = RW'(qy_s1);
		rect_c = (qx_w >= -sa_w) && (qx_w <= sa_w) && (qy_w >= -sb_w) && (qy_w <= sb_w);
		hx     = qx_s1 >>> 1;
		hy     = qy_s1 >>> 1;
		ax     = hx[QW-1] ? -hx : hx;
		ay     = hy[QW-1] ? -hy : hy;
		box_c  = (ax <= QW'(sa_s1)) && (ay <= QW'(sa_s1));
	end

	logic [SQ_W-1:0] tsum;
	logic [SQ_W:0]   sqsum;

	always_comb begin
		tsum  = tprod_s2 + T_HALF;
		sqsum = (SQ_W+1)'(sqx_s3) + (SQ_W+1)'(sqy_s3);
	end

	// triangle edge sign and final select
	logic tri_neg, tri_pos, tri_hit, hit_c;

	always_comb begin
		tri_neg = |lt_s34;
		tri_pos = |gt_s34;
		tri_hit = side_s[ST_CMP].size_zero ? side_s[ST_CMP].ctr_eq : !(tri_neg && tri_pos);
		case (side_s[ST_CMP].op)
			SHAPE_RECT:   hit_c = side_s[ST_CMP].rect_hit;
			SHAPE_TRI:    hit_c = tri_hit;
			SHAPE_CIRCLE: hit_c = side_s[ST_CMP].circ_hit;
			default:      hit_c = 1'b0;
		endcase
	end

	assign go          = !skid_v_q;
	assign take        = !out_v_q || result.ready;
	assign query.ready = go;
	assign result.valid      = out_v_q;
	assign result.inside_res = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (go) begin
			vld_s <= {vld_s[NST-1:1], query.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			// s1
			op_s1  <= query.op;
			qx_s1  <= {dx_in, 1'b0};
			qy_s1  <= {dy_in, 1'b0};
			sa_s1  <= query.size_a;
			sb_s1  <= query.size_b;
			cx_s[1] <= CORDIC_GAIN;
			cy_s[1] <= '0;
			cz_s[1] <= z_fold;
			cf_s[1] <= flip_in;
			// s2
			op_s2    <= op_s1;
			qx_s2    <= qx_s1;
			qy_s2    <= qy_s1;
			sa_s2    <= sa_s1;
			rect_s2  <= rect_c;
			box_s2   <= box_c;
			szero_s2 <= (sa_s1 == '0);
			eq_s2    <= (qx_s1 == '0) && (qy_s1 == '0);
			adx_s2   <= ax[SIZE_W-1:0];
			ady_s2   <= ay[SIZE_W-1:0];
			tprod_s2 <= SQ_W'(sa_s1) * SQ_W'(SQRT3_Q30);
			// s3
			op_s3    <= op_s2;
			qx_s3    <= qx_s2;
			qy_s3    <= qy_s2;
			sa_s3    <= sa_s2;
			rect_s3  <= rect_s2;
			box_s3   <= box_s2;
			szero_s3 <= szero_s2;
			eq_s3    <= eq_s2;
			sqx_s3   <= SQ_W'(adx_s2) * SQ_W'(adx_s2);
			sqy_s3   <= SQ_W'(ady_s2) * SQ_W'(ady_s2);
			sqr_s3   <= SQ_W'(sa_s2) * SQ_W'(sa_s2);
			t_s3     <= tsum[SQ_W-1:CS_FRAC];
			// s4
			side_s[4].op        <= op_s3;
			side_s[4].rect_hit  <= rect_s3;
			side_s[4].circ_hit  <= box_s3 && (sqsum <= (SQ_W+1)'(sqr_s3));
			side_s[4].size_zero <= szero_s3;
			side_s[4].ctr_eq    <= eq_s3;
			side_s[4].qx        <= qx_s3;
			side_s[4].qy        <= qy_s3;
			side_s[4].s         <= sa_s3;
			side_s[4].t         <= t_s3;
			// cos/sin
			c_s26  <= cf_s[ST_CE] ? -cx_s[ST_CE] : cx_s[ST_CE];
			sn_s26 <= cf_s[ST_CE] ? -cy_s[ST_CE] : cy_s[ST_CE];
			// rotation products
			ptc_s27 <= $signed({1'b0, side_s[ST_TRIG].t}) * c_s26;
			pts_s27 <= $signed({1'b0, side_s[ST_TRIG].t}) * sn_s26;
			psc_s27 <= $signed({1'b0, side_s[ST_TRIG].s}) * c_s26;
			pss_s27 <= $signed({1'b0, side_s[ST_TRIG].s}) * sn_s26;
			// each product rounded on its own
			rss2_s28 <= rnd30(pss_s27 <<< 1);
			rsc2_s28 <= rnd30(psc_s27 <<< 1);
			rtc_s28  <= rnd30(ptc_s27);
			rnss_s28 <= rnd30(-pss_s27);
			rts_s28  <= rnd30(pts_s27);
			rnsc_s28 <= rnd30(-psc_s27);
			rntc_s28 <= rnd30(-ptc_s27);
			rnts_s28 <= rnd30(-pts_s27);
			// vertices, doubled units
			vx_s29[0] <= -rss2_s28;
			vy_s29[0] <= rsc2_s28;
			vx_s29[1] <= rtc_s28 - rnss_s28;
			vy_s29[1] <= rts_s28 + rnsc_s28;
			vx_s29[2] <= rntc_s28 - rnss_s28;
			vy_s29[2] <= rnts_s28 + rnsc_s28;
			hit_s35 <= hit_c;
		end
	end

	// edge i runs from vertex i+1 (mod 3) to vertex i
	always_ff @(posedge clk) begin
		if (go) begin
			for (int i = 0; i < 3; i++) begin
				ma_s30[2*i]   <= OPD_W'($signed(side_s[ST_VTX].qx)) -
					OPD_W'(vx_s29[(i == 2) ? 0 : i + 1]);
				mb_s30[2*i]   <= OPD_W'(vy_s29[i]) - OPD_W'(vy_s29[(i == 2) ? 0 : i + 1]);
				ma_s30[2*i+1] <= OPD_W'(vx_s29[i]) - OPD_W'(vx_s29[(i == 2) ? 0 : i + 1]);
				mb_s30[2*i+1] <= OPD_W'($signed(side_s[ST_VTX].qy)) -
					OPD_W'(vy_s29[(i == 2) ? 0 : i + 1]);
			end
			for (int m = 0; m < NPROD; m++) begin
				hh_s31[m] <= $signed(ma_s30[m][OPD_W-1:HALF_W]) *
					$signed(mb_s30[m][OPD_W-1:HALF_W]);
				hl_s31[m] <= $signed(ma_s30[m][OPD_W-1:HALF_W]) *
					$signed({1'b0, mb_s30[m][HALF_W-1:0]});
				lh_s31[m] <= $signed({1'b0, ma_s30[m][HALF_W-1:0]}) *
					$signed(mb_s30[m][OPD_W-1:HALF_W]);
				ll_s31[m] <= OPD_W'(ma_s30[m][HALF_W-1:0]) * OPD_W'(mb_s30[m][HALF_W-1:0]);
				hh_s32[m]  <= hh_s31[m];
				mid_s32[m] <= MID_W'(hl_s31[m]) + MID_W'(lh_s31[m]);
				ll_s32[m]  <= ll_s31[m];
				prod_s33[m] <= (PW'(hh_s32[m]) << OPD_W) + (PW'(mid_s32[m]) << HALF_W) +
					PW'(ll_s32[m]);
			end
			for (int i = 0; i < 3; i++) begin
				lt_s34[i] <= prod_s33[2*i] < prod_s33[2*i+1];
				gt_s34[i] <= prod_s33[2*i] > prod_s33[2*i+1];
			end
		end
	end

	for (genvar k = 2; k <= ST_CE; k++) begin : g_cordic
		always_ff @(posedge clk) begin
			if (go) begin
				if (!cz_s[k-1][Z_W-1]) begin
					cx_s[k] <= cx_s[k-1] - (cy_s[k-1] >>> (k - 2));
					cy_s[k] <= cy_s[k-1] + (cx_s[k-1] >>> (k - 2));
					cz_s[k] <= cz_s[k-1] - ATAN_TURNS[k-2];
				end else begin
					cx_s[k] <= cx_s[k-1] + (cy_s[k-1] >>> (k - 2));
					cy_s[k] <= cy_s[k-1] - (cx_s[k-1] >>> (k - 2));
					cz_s[k] <= cz_s[k-1] + ATAN_TURNS[k-2];
				end
				cf_s[k] <= cf_s[k-1];
			end
		end
	end

	for (genvar k = 5; k < NST; k++) begin : g_side
		always_ff @(posedge clk) begin
			if (go) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// output register with one skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= vld_s[NST];
			end
		end else if (!skid_v_q && vld_s[NST]) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= skid_v_q ? skid_q : hit_s35;
		end else if (!skid_v_q) begin
			skid_q <= hit_s35;
		end
	end

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> out_v_q)
		else $error("skid entry held while output register empty");

	a_unused_op_miss: assert property (@(posedge clk) disable iff (!arst_n)
		(go && vld_s[ST_CMP] && side_s[ST_CMP].op != SHAPE_RECT &&
		 side_s[ST_CMP].op != SHAPE_TRI && side_s[ST_CMP].op != SHAPE_CIRCLE)
		|=> (vld_s[NST] && !hit_s35))
		else $error("unused shape kind reported a hit");

	a_trig_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[ST_TRIG] |-> (c_s26 <= TRIG_LIM && c_s26 >= -TRIG_LIM &&
		                    sn_s26 <= TRIG_LIM && sn_s26 >= -TRIG_LIM))
		else $error("CORDIC output out of range");

endmodule

@@ bench/hit_test_checker.sv @@
`timescale 1ns / 100ps

module hit_test_checker (
	input  logic   clk,
	input  logic   arst_n,
	pist_query_if  query,
	pist_result_if result,
	output int     mismatches,
	output int     pending,
	output int     results_seen,
	output int     hits_seen
);
	import pist_pkg::*;

	localparam int     ROT_STEPS    = 24;
	localparam int     REPORT_LIMIT = 10;
	localparam longint TURN_FULL    = 64'sh1_0000_0000;
	localparam longint TURN_HALF    = 64'sh8000_0000;
	localparam longint TURN_QUARTER = 64'sh4000_0000;
	localparam longint ROT_GAIN     = 64'sd652032874;
	localparam longint ROUND_Q30    = 64'sd536870912;
	localparam logic [63:0] ROOT3_Q30 = 64'd1859775393;
	localparam logic [63:0] HALF_LSB_Q30 = 64'd536870912;

	localparam longint ATAN_STEP [ROT_STEPS] = '{
		64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
		64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
		64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
		64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D,
		64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
		64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
	};

	logic expected_inside [$];
	int   fail_count;
	int   result_index;
	int   hit_count;

	// rotation-mode CORDIC, gain pre-applied; outputs are Q2.30
	function automatic void sincos(input logic [PHASE_W-1:0] phase, output longint cos_v,
		output longint sin_v);
		longint z, x, y, dx, dy;
		bit     flip;
		int     i;
		z = {32'd0, phase};
		if (z >= TURN_HALF)
			z -= TURN_FULL;
		flip = 1'b0;
		if (z > TURN_QUARTER) begin
			z -= TURN_HALF;
			flip = 1'b1;
		end else if (z < -TURN_QUARTER) begin
			z += TURN_HALF;
			flip = 1'b1;
		end
		x = ROT_GAIN;
		y = 0;
		for (i = 0; i < ROT_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx;
				y += dy;
				z -= ATAN_STEP[i];
			end else begin
				x += dx;
				y -= dy;
				z += ATAN_STEP[i];
			end
		end
		cos_v = flip ? -x : x;
		sin_v = flip ? -y : y;
	endfunction

	// floor((a*b + 2^29) / 2^30)
	function automatic longint round_q30(input longint a, input longint b);
		logic signed [127:0] wa, wb, p;
		wa = a;
		wb = b;
		p = wa * wb + ROUND_Q30;
		return longint'(p >>> 30);
	endfunction

	// sign of a*b - c*d, exact
	function automatic int cross_sign(input longint a, input longint b, input longint c,
		input longint d);
		logic signed [127:0] wa, wb, wc, wd, diff;
		wa = a;
		wb = b;
		wc = c;
		wd = d;
		diff = wa * wb - wc * wd;
		if (diff < 0)
			return -1;
		return (diff == 0) ? 0 : 1;
	endfunction

	// q is the point offset from the centre in half-LSB units
	function automatic logic triangle_inside(input longint qx, input longint qy,
		input logic [SIZE_W-1:0] sa, input logic [ROT_W-1:0] rot);
		logic [63:0] s_u, t_u;
		longint      s, t, cs, sn;
		longint      lx [3], ly [3], vx [3], vy [3];
		int          i, j, sgn;
		bit          neg, pos;
		s_u = sa;
		t_u = (s_u * ROOT3_Q30 + HALF_LSB_Q30) >> 30;
		s = s_u;
		t = t_u;
		lx[0] = 0;
		ly[0] = 2 * s;
		lx[1] = t;
		ly[1] = -s;
		lx[2] = -t;
		ly[2] = -s;
		sincos({rot[ANGLE_BITS-1:0], {(PHASE_W-ANGLE_BITS){1'b0}}}, cs, sn);
		for (i = 0; i < 3; i++) begin
			vx[i] = round_q30(lx[i], cs) - round_q30(ly[i], sn);
			vy[i] = round_q30(lx[i], sn) + round_q30(ly[i], cs);
		end
		neg = 1'b0;
		pos = 1'b0;
		for (i = 0; i < 3; i++) begin
			j = (i + 1) % 3;
			sgn = cross_sign(qx - vx[j], vy[i] - vy[j], vx[i] - vx[j], qy - vy[j]);
			if (sgn < 0)
				neg = 1'b1;
			if (sgn > 0)
				pos = 1'b1;
		end
		return !(neg && pos);
	endfunction

	function automatic logic predict_inside(input logic [OP_W-1:0] op,
		input logic signed [COORD_W-1:0] px, input logic signed [COORD_W-1:0] py,
		input logic signed [COORD_W-1:0] cx, input logic signed [COORD_W-1:0] cy,
		input logic [SIZE_W-1:0] sa, input logic [SIZE_W-1:0] sb,
		input logic [ROT_W-1:0] rot);
		longint      lpx, lpy, lcx, lcy, w, h, dx, dy;
		logic [63:0] ux, uy, ur;
		logic        hit;
		lpx = px;
		lpy = py;
		lcx = cx;
		lcy = cy;
		w = sa;
		h = sb;
		hit = 1'b0;
		case (shape_t'(op))
		SHAPE_RECT: begin
			hit = (2 * lcx - w <= 2 * lpx) && (2 * lpx <= 2 * lcx + w) &&
				(2 * lcy - h <= 2 * lpy) && (2 * lpy <= 2 * lcy + h);
		end
		SHAPE_TRI: begin
			if (sa == '0)
				hit = (px == cx) && (py == cy);
			else
				hit = triangle_inside(2 * (lpx - lcx), 2 * (lpy - lcy), sa, rot);
		end
		SHAPE_CIRCLE: begin
			dx = lpx - lcx;
			dy = lpy - lcy;
			if (dx < 0)
				dx = -dx;
			if (dy < 0)
				dy = -dy;
			if (dx <= w && dy <= w) begin
				ux = dx;
				uy = dy;
				ur = w;
				hit = (ux * ux + uy * uy) <= (ur * ur);
			end
		end
		default: begin
			hit = 1'b0;
		end
		endcase
		return hit;
	endfunction

	initial begin
		fail_count = 0;
		result_index = 0;
		hit_count = 0;
		mismatches = 0;
		pending = 0;
		results_seen = 0;
		hits_seen = 0;
	end

	// results are popped before the new query is pushed, so a result can never
	// match a query accepted in the same cycle
	always @(posedge clk) begin
		if (arst_n) begin
			if (result.valid && result.ready) begin
				if (expected_inside.size() == 0) begin
					if (fail_count < REPORT_LIMIT)
						$display("%0t: unexpected result transaction, inside_res=%0b",
							$realtime, result.inside_res);
					fail_count++;
				end else begin
					if (result.inside_res !== expected_inside[0]) begin
						if (fail_count < REPORT_LIMIT)
							$display("%0t: result %0d inside_res expected %0b got %0b",
								$realtime, result_index, expected_inside[0],
								result.inside_res);
						fail_count++;
					end
					void'(expected_inside.pop_front());
				end
				if (result.inside_res === 1'b1)
					hit_count++;
				result_index++;
			end
			if (query.valid && query.ready)
				expected_inside.push_back(predict_inside(query.op, query.point_x,
					query.point_y, query.center_x, query.center_y, query.size_a,
					query.size_b, query.rotation));
			mismatches <= fail_count;
			pending <= expected_inside.size();
			results_seen <= result_index;
			hits_seen <= hit_count;
		end
	end

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
	import pist_pkg::*;

	localparam logic [OP_W-1:0] SHAPE_UNUSED = 2'd3;
	localparam int RANDOM_PER_PHASE = 450;
	localparam int DRAIN_CYCLES     = 40;
	localparam int STALL_LIMIT      = 4000;
	localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
	localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [COORD_W-1:0] ONE   = 32'sd65536;
	localparam logic [SIZE_W-1:0]         S_MAX = '1;

	logic clk;
	logic arst_n;
	int   send_idle_pct;
	int   recv_stall_pct;
	int   mismatches, pending, results_seen, hits_seen;
	int   sent_per_kind [4];
	int   idle_run;

	pist_query_if  query ();
	pist_result_if result ();

	point_in_shape_hit_test dut (
		.clk    (clk),
		.arst_n (arst_n),
		.query  (query),
		.result (result)
	);

	hit_test_checker hit_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.query        (query),
		.result       (result),
		.mismatches   (mismatches),
		.pending      (pending),
		.results_seen (results_seen),
		.hits_seen    (hits_seen)
	);

	initial clk = 1'b0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(negedge clk) begin
		result.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (query.valid && query.ready) || (result.valid && result.ready)) begin
			idle_run <= 0;
		end else if (idle_run >= STALL_LIMIT) begin
			$display("no transaction for %0d cycles", STALL_LIMIT);
			$display("DONE: errors detected");
			$finish;
		end else begin
			idle_run <= idle_run + 1;
		end
	end

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic send_query(input logic [OP_W-1:0] op,
		input logic signed [COORD_W-1:0] px, input logic signed [COORD_W-1:0] py,
		input logic signed [COORD_W-1:0] cx, input logic signed [COORD_W-1:0] cy,
		input logic [SIZE_W-1:0] sa, input logic [SIZE_W-1:0] sb,
		input logic [ROT_W-1:0] rot);
		while ($urandom_range(99) < send_idle_pct) begin
			query.valid <= 1'b0;
			@(negedge clk);
		end
		query.valid <= 1'b1;
		query.op <= op;
		query.point_x <= px;
		query.point_y <= py;
		query.center_x <= cx;
		query.center_y <= cy;
		query.size_a <= sa;
		query.size_b <= sb;
		query.rotation <= rot;
		do
			@(posedge clk);
		while (!query.ready);
		sent_per_kind[op]++;
		@(negedge clk);
	endtask

	function automatic longint near_offset(input longint span);
		longint mag;
		mag = $urandom_range(32'(span));
		return $urandom_range(1) ? mag : -mag;
	endfunction

	// mostly points scattered around the shape so that hits and misses mix;
	// a share of raw noise covers every bit of the coordinates
	task automatic random_query();
		int                          pick;
		logic [OP_W-1:0]             op;
		logic signed [COORD_W-1:0]   px, py, cx, cy;
		logic [SIZE_W-1:0]           sa, sb;
		logic [ROT_W-1:0]            rot;
		longint                      span_x, span_y, ox, oy;
		pick = $urandom_range(99);
		op = (pick < 3) ? SHAPE_UNUSED : OP_W'($urandom_range(2));
		sa = SIZE_W'($urandom >> $urandom_range(31, 1));
		sb = SIZE_W'($urandom >> $urandom_range(31, 1));
		rot = ROT_W'($urandom);
		cx = $urandom;
		cy = $urandom;
		if ($urandom_range(3) == 0) begin
			cx = cx >>> $urandom_range(31, 8);
			cy = cy >>> $urandom_range(31, 8);
		end
		if (pick < 15) begin
			px = $urandom;
			py = $urandom;
		end else begin
			if (op == SHAPE_RECT) begin
				span_x = longint'(sa) + 1;
				span_y = longint'(sb) + 1;
			end else begin
				span_x = longint'(sa) + (longint'(sa) >> 2) + 1;
				span_y = span_x;
			end
			ox = near_offset(span_x);
			oy = near_offset(span_y);
			if (op == SHAPE_RECT && $urandom_range(4) == 0)
				ox = $urandom_range(1) ? longint'(sa >> 1) : -longint'(sa >> 1);
			if (op == SHAPE_CIRCLE && $urandom_range(5) == 0) begin
				ox = $urandom_range(1) ? longint'(sa) : -longint'(sa);
				oy = 0;
			end
			px = COORD_W'(longint'(cx) + ox);
			py = COORD_W'(longint'(cy) + oy);
		end
		send_query(op, px, py, cx, cy, sa, sb, rot);
	endtask

	task automatic directed_queries();
		send_query(SHAPE_RECT, 0, 0, 0, 0, 0, 0, 0);
		send_query(SHAPE_RECT, 1, 0, 0, 0, 0, 0, 0);
		send_query(SHAPE_RECT, 10 * ONE, -5 * ONE, 0, 0, 20 * ONE, 10 * ONE, 16'h1234);
		send_query(SHAPE_RECT, 10 * ONE + 1, 0, 0, 0, 20 * ONE, 10 * ONE, 0);
		send_query(SHAPE_RECT, C_MIN, C_MAX, C_MIN, C_MAX, S_MAX, S_MAX, '1);
		send_query(SHAPE_RECT, C_MAX, C_MIN, C_MIN, C_MAX, S_MAX, S_MAX, 0);
		send_query(SHAPE_TRI, 3 * ONE, -2 * ONE, 3 * ONE, -2 * ONE, 0, S_MAX, 0);
		send_query(SHAPE_TRI, 3 * ONE + 1, -2 * ONE, 3 * ONE, -2 * ONE, 0, 0, 0);
		send_query(SHAPE_TRI, 0, 0, 0, 0, ONE, 0, 0);
		send_query(SHAPE_TRI, 0, ONE, 0, 0, ONE, 0, 0);
		send_query(SHAPE_TRI, 0, 2 * ONE, 0, 0, ONE, 0, 0);
		send_query(SHAPE_TRI, 0, -ONE / 2, 0, 0, ONE, 0, 0);
		send_query(SHAPE_TRI, 0, ONE - 1, 0, 0, ONE, 0, 16'h4000);
		send_query(SHAPE_TRI, 0, ONE - 1, 0, 0, ONE, 0, 16'h8000);
		send_query(SHAPE_TRI, 0, ONE - 1, 0, 0, ONE, 0, 16'hC000);
		send_query(SHAPE_TRI, 0, ONE - 1, 0, 0, ONE, S_MAX, 16'hFFFF);
		send_query(SHAPE_TRI, C_MAX, C_MAX, C_MIN, C_MIN, S_MAX, 0, 16'h2AAA);
		send_query(SHAPE_TRI, C_MIN, C_MIN, C_MAX, C_MAX, S_MAX, S_MAX, 16'h8000);
		send_query(SHAPE_CIRCLE, 0, 0, 0, 0, 0, 0, 0);
		send_query(SHAPE_CIRCLE, 3 * ONE, 4 * ONE, 0, 0, 5 * ONE, 0, 0);
		send_query(SHAPE_CIRCLE, 4 * ONE, 4 * ONE, 0, 0, 5 * ONE, S_MAX, '1);
		send_query(SHAPE_CIRCLE, 5 * ONE + 1, 0, 0, 0, 5 * ONE, 0, 0);
		send_query(SHAPE_CIRCLE, C_MAX, C_MIN, C_MIN, C_MAX, S_MAX, 0, 0);
		send_query(SHAPE_CIRCLE, C_MIN, 0, 0, 0, S_MAX, 0, 0);
		send_query(SHAPE_UNUSED, 0, 0, 0, 0, ONE, ONE, 0);
	endtask

	initial begin
		arst_n = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		idle_run = 0;
		sent_per_kind = '{default: 0};
		query.valid = 1'b0;
		query.op = '0;
		query.point_x = '0;
		query.point_y = '0;
		query.center_x = '0;
		query.center_y = '0;
		query.size_a = '0;
		query.size_b = '0;
		query.rotation = '0;
		result.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		directed_queries();
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin
				send_idle_pct = 0;
				recv_stall_pct = 0;
			end
			1: begin
				send_idle_pct = 84;
				recv_stall_pct = 0;
			end
			2: begin
				send_idle_pct = 0;
				recv_stall_pct = 84;
			end
			default: begin
				send_idle_pct = 35;
				recv_stall_pct = 35;
			end
			endcase
			repeat (RANDOM_PER_PHASE) random_query();
			query.valid <= 1'b0;
			wait (pending == 0);
			@(negedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d rectangle, %0d triangle, %0d circle, %0d unused-kind queries",
			sent_per_kind[SHAPE_RECT], sent_per_kind[SHAPE_TRI],
			sent_per_kind[SHAPE_CIRCLE], sent_per_kind[SHAPE_UNUSED]);
		$display("over four flow-control phases; %0d results checked, %0d inside",
			results_seen, hits_seen);
		if (mismatches == 0 && pending == 0) begin
			$display("DONE: 0 errors");
		end else begin
			if (pending != 0)
				$display("%0d expected results never arrived", pending);
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
